[rtl/tpds_pkg.sv]
// Shared types and constants for the torus point depth shader.
// Holds register indices, reset values, multiplier program codes and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package tpds_pkg;

    localparam int SCREEN_WIDTH_DEF  = 32;
    localparam int SCREEN_HEIGHT_DEF = 32;

    localparam int CFG_NUM = 8;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 16;

    localparam logic [CFG_IW-1:0] REG_COS_A = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SIN_A = 3'd1;
    localparam logic [CFG_IW-1:0] REG_COS_B = 3'd2;
    localparam logic [CFG_IW-1:0] REG_SIN_B = 3'd3;
    localparam logic [CFG_IW-1:0] REG_TUBE  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_RING  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_VIEW  = 3'd6;
    localparam logic [CFG_IW-1:0] REG_PROJ  = 3'd7;

    localparam logic [CFG_DW-1:0] CFG_RESET [CFG_NUM] = '{
        16'd16384, 16'd0, 16'd16384, 16'd0, 16'd4096, 16'd8192, 16'd20480, 16'd4800
    };

    // Luminance is Q.14; ramp index is lum >> 11, capped at the top step.
    localparam int LUM_SHIFT = 11;
    localparam int LEVEL_TOP = 11;

    typedef logic [4:0] t_op;

    // Multiplier program, issued in this order for a plot word.
    localparam t_op OP_CX    = 5'd0;
    localparam t_op OP_CY    = 5'd1;
    localparam t_op OP_SASB  = 5'd2;
    localparam t_op OP_SACB  = 5'd3;
    localparam t_op OP_M2    = 5'd4;
    localparam t_op OP_N2    = 5'd5;
    localparam t_op OP_M1    = 5'd6;
    localparam t_op OP_N1    = 5'd7;
    localparam t_op OP_M1ACC = 5'd8;
    localparam t_op OP_N1ACC = 5'd9;
    localparam t_op OP_U     = 5'd10;
    localparam t_op OP_V     = 5'd11;
    localparam t_op OP_W     = 5'd12;
    localparam t_op OP_Q     = 5'd13;
    localparam t_op OP_LUM0  = 5'd14;
    localparam t_op OP_LUM1  = 5'd15;
    localparam t_op OP_LUM2  = 5'd16;
    localparam t_op OP_WACC  = 5'd17;
    localparam t_op OP_ZT    = 5'd18;
    localparam t_op OP_LUM3  = 5'd19;
    localparam t_op OP_Z0    = 5'd20;
    localparam t_op OP_Z1    = 5'd21;
    localparam t_op OP_XS    = 5'd22;
    localparam t_op OP_X     = 5'd23;
    localparam t_op OP_YS    = 5'd24;
    localparam t_op OP_Y     = 5'd25;
    localparam t_op OP_KZ    = 5'd26;
    localparam t_op OP_PX    = 5'd27;
    localparam t_op OP_PY    = 5'd28;

    typedef struct packed {
        logic load;          // capture input word
        logic res_clr;       // clear pending result
        logic op_vld;        // issue a multiply
        t_op  op;
        logic div_init;
        logic div_step;
        logic sat;           // reciprocal saturates
        logic clr;           // one step of the clearing sweep
        logic rd_pix;        // read stores at the requested pixel
        logic wr_pix_clear;  // return level and blank the requested pixel
        logic rd_plot;       // read depth at the projected pixel
        logic wr_plot;       // depth test and store
        logic out_load;      // move result to output register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic lum_pos;
        logic z_pos;
        logic z_small;
        logic onscreen;
    } t_sts;

endpackage

`default_nettype wire

[rtl/tpds_dp.sv]
// Datapath: config registers, shared multiplier, reciprocal divider,
// pixel stores and result registers. Depends on tpds_pkg.
`default_nettype none

module tpds_dp
    import tpds_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [CFG_IW-1:0]   i_cfg_idx,
    input  wire [CFG_DW-1:0]   i_cfg_data,
    input  wire signed [15:0]  i_ct,
    input  wire signed [15:0]  i_st,
    input  wire signed [15:0]  i_cp,
    input  wire signed [15:0]  i_sp,
    input  wire [4:0]          i_row,
    input  wire [4:0]          i_col,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic [3:0]         o_level,
    output logic               o_drawn
);

    localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW   = $clog2(NPIX);

    logic [CFG_DW-1:0] r_cfg [CFG_NUM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) r_cfg[i] <= CFG_RESET[i];
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    logic signed [15:0] ca, sa, cb, sb;
    logic [15:0] r1, r2, k2, k1;
    assign ca = $signed(r_cfg[REG_COS_A]);
    assign sa = $signed(r_cfg[REG_SIN_A]);
    assign cb = $signed(r_cfg[REG_COS_B]);
    assign sb = $signed(r_cfg[REG_SIN_B]);
    assign r1 = r_cfg[REG_TUBE];
    assign r2 = r_cfg[REG_RING];
    assign k2 = r_cfg[REG_VIEW];
    assign k1 = r_cfg[REG_PROJ];

    logic signed [15:0] r_ct, r_st, r_cp, r_sp;
    logic [4:0] r_prow, r_pcol;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ct   <= i_ct;
            r_st   <= i_st;
            r_cp   <= i_cp;
            r_sp   <= i_sp;
            r_prow <= i_row;
            r_pcol <= i_col;
        end
    end

    logic signed [23:0] r_cx, r_cy, r_ta, r_tb, r_m2, r_n2, r_m1, r_n1;
    logic signed [23:0] r_tu, r_tv, r_tw, r_tq, r_tz, r_lum, r_z;
    logic signed [39:0] r_xs, r_ys;
    logic signed [24:0] r_x, r_y;
    logic signed [32:0] r_kz;
    logic signed [22:0] r_colp, r_rowp;
    logic [15:0] r_zi;

    // operand select
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_CX:    begin mul_a = $signed({17'b0, r1}); mul_b = 25'(r_ct); end
            OP_CY:    begin mul_a = $signed({17'b0, r1}); mul_b = 25'(r_st); end
            OP_SASB:  begin mul_a = 33'(sa);   mul_b = 25'(sb);   end
            OP_SACB:  begin mul_a = 33'(sa);   mul_b = 25'(cb);   end
            OP_M2:    begin mul_a = 33'(ca);   mul_b = 25'(sb);   end
            OP_N2:    begin mul_a = 33'(ca);   mul_b = 25'(cb);   end
            OP_M1:    begin mul_a = 33'(cb);   mul_b = 25'(r_cp); end
            OP_N1:    begin mul_a = 33'(sb);   mul_b = 25'(r_cp); end
            OP_M1ACC: begin mul_a = 33'(r_ta); mul_b = 25'(r_sp); end
            OP_N1ACC: begin mul_a = 33'(r_tb); mul_b = 25'(r_sp); end
            OP_U:     begin mul_a = 33'(ca);   mul_b = 25'(r_ct); end
            OP_V:     begin mul_a = 33'(r_cp); mul_b = 25'(r_ct); end
            OP_W:     begin mul_a = 33'(ca);   mul_b = 25'(r_st); end
            OP_Q:     begin mul_a = 33'(r_ct); mul_b = 25'(sa);   end
            OP_LUM0:  begin mul_a = 33'(sa);   mul_b = 25'(r_st); end
            OP_LUM1:  begin mul_a = 33'(r_tv); mul_b = 25'(sb);   end
            OP_LUM2:  begin mul_a = 33'(r_tu); mul_b = 25'(r_sp); end
            OP_WACC:  begin mul_a = 33'(r_tq); mul_b = 25'(r_sp); end
            OP_ZT:    begin mul_a = 33'(ca);   mul_b = 25'(r_cx); end
            OP_LUM3:  begin mul_a = 33'(cb);   mul_b = 25'(r_tw); end
            OP_Z0:    begin mul_a = 33'(r_cy); mul_b = 25'(sa);   end
            OP_Z1:    begin mul_a = 33'(r_tz); mul_b = 25'(r_sp); end
            OP_XS:    begin mul_a = 33'(r_cx); mul_b = 25'(r_m1); end
            OP_X:     begin mul_a = 33'(r_cy); mul_b = 25'(r_m2); end
            OP_YS:    begin mul_a = 33'(r_cx); mul_b = 25'(r_n1); end
            OP_Y:     begin mul_a = 33'(r_cy); mul_b = 25'(r_n2); end
            OP_KZ:    begin mul_a = $signed({17'b0, k1}); mul_b = $signed({9'b0, r_zi}); end
            OP_PX:    begin mul_a = r_kz; mul_b = r_x;  end
            OP_PY:    begin mul_a = r_kz; mul_b = -r_y; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    logic signed [57:0] r_p;
    logic r_wb_vld;
    t_op  r_wb_op;

    always_ff @(posedge i_clk) begin
        r_p     <= mul_a * mul_b;
        r_wb_op <= i_cmd.op;
        if (!i_rst_n) r_wb_vld <= 1'b0;
        else          r_wb_vld <= i_cmd.op_vld;
    end

    // rescaled product, floor rounding through the arithmetic shift
    logic signed [23:0] p14;
    logic signed [39:0] p40;
    logic signed [22:0] p36;
    assign p14 = 24'(r_p >>> 14);
    assign p40 = r_p[39:0];
    assign p36 = 23'(r_p >>> 36);

    always_ff @(posedge i_clk) begin
        if (r_wb_vld) begin
            unique case (r_wb_op)
                OP_CX:    r_cx  <= $signed({8'b0, r2}) + p14;
                OP_CY:    r_cy  <= p14;
                OP_SASB:  r_ta  <= p14;
                OP_SACB:  r_tb  <= p14;
                OP_M2:    r_m2  <= p14;
                OP_N2:    r_n2  <= p14;
                OP_M1:    r_m1  <= p14;
                OP_N1:    r_n1  <= p14;
                OP_M1ACC: r_m1  <= r_m1 + p14;
                OP_N1ACC: r_n1  <= r_n1 - p14;
                OP_U:     r_tu  <= p14;
                OP_V:     r_tv  <= p14;
                OP_W:     r_tw  <= p14;
                OP_Q:     r_tq  <= p14;
                OP_LUM0:  r_lum <= -p14;
                OP_LUM1:  r_lum <= r_lum + p14;
                OP_LUM2:  r_lum <= r_lum - p14;
                OP_WACC:  r_tw  <= r_tw - p14;
                OP_ZT:    r_tz  <= p14;
                OP_LUM3:  r_lum <= r_lum + p14;
                OP_Z0:    r_z   <= $signed({8'b0, k2}) + p14;
                OP_Z1:    r_z   <= r_z + p14;
                OP_XS:    r_xs  <= p40;
                OP_X:     r_x   <= 25'((r_xs - p40) >>> 14);
                OP_YS:    r_ys  <= p40;
                OP_Y:     r_y   <= 25'((r_ys + p40) >>> 14);
                OP_KZ:    r_kz  <= r_p[32:0];
                OP_PX:    r_colp <= p36 + 23'(SCREEN_WIDTH / 2);
                OP_PY:    r_rowp <= p36 + 23'(SCREEN_HEIGHT / 2);
                default:  ;
            endcase
        end
    end

    // restoring division of 2^28 by z, one quotient bit a cycle
    logic [37:0] r_rem, r_dsr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sat) begin
            r_zi <= 16'hFFFF;
        end else if (i_cmd.div_init) begin
            r_rem <= 38'h0010000000;
            r_dsr <= {14'b0, r_z} << 15;
            r_zi  <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dsr) begin
                r_rem <= r_rem - r_dsr;
                r_zi  <= {r_zi[14:0], 1'b1};
            end else begin
                r_zi  <= {r_zi[14:0], 1'b0};
            end
            r_dsr <= r_dsr >> 1;
        end
    end

    // pixel stores
    logic [15:0] mem_depth [NPIX];
    logic [3:0]  mem_level [NPIX];
    logic [15:0] r_rd_depth;
    logic [3:0]  r_rd_level;
    logic [AW-1:0] r_clr_addr, addr, pix_addr, plot_addr;
    logic pix_ok, gt, we;
    logic [15:0] wr_depth;
    logic [3:0]  wr_level, lvl;
    logic signed [23:0] lum_idx;

    assign pix_ok    = (int'(r_prow) < SCREEN_HEIGHT) && (int'(r_pcol) < SCREEN_WIDTH);
    assign pix_addr  = AW'(int'(r_prow) * SCREEN_WIDTH + int'(r_pcol));
    assign plot_addr = AW'(int'(r_rowp) * SCREEN_WIDTH + int'(r_colp));
    assign gt        = r_zi > r_rd_depth;
    assign lum_idx   = r_lum >>> LUM_SHIFT;
    assign lvl       = (lum_idx > 24'sd11) ? 4'(LEVEL_TOP + 1) : lum_idx[3:0] + 4'd1;

    always_comb begin
        addr     = plot_addr;
        we       = 1'b0;
        wr_depth = '0;
        wr_level = '0;
        if (i_cmd.clr) begin
            addr = r_clr_addr;
            we   = 1'b1;
        end else if (i_cmd.rd_pix || i_cmd.wr_pix_clear) begin
            addr = pix_addr;
            we   = i_cmd.wr_pix_clear && pix_ok;
        end else if (i_cmd.wr_plot && gt) begin
            we       = 1'b1;
            wr_depth = r_zi;
            wr_level = lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_depth[addr] <= wr_depth;
            mem_level[addr] <= wr_level;
        end
        if ((i_cmd.rd_pix && pix_ok) || i_cmd.rd_plot) begin
            r_rd_depth <= mem_depth[addr];
            r_rd_level <= mem_level[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)        r_clr_addr <= '0;
        else if (i_cmd.clr)  r_clr_addr <= r_clr_addr + AW'(1);
    end

    // result and output registers
    logic [3:0] r_res_level;
    logic       r_res_drawn;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clr) begin
            r_res_level <= '0;
            r_res_drawn <= 1'b0;
        end else if (i_cmd.wr_pix_clear) begin
            r_res_level <= pix_ok ? r_rd_level : 4'd0;
        end else if (i_cmd.wr_plot) begin
            r_res_drawn <= gt;
        end
        if (i_cmd.out_load) begin
            o_level <= r_res_level;
            o_drawn <= r_res_drawn;
        end
    end

    assign o_sts.clr_last = r_clr_addr == AW'(NPIX - 1);
    assign o_sts.lum_pos  = r_lum > 24'sd0;
    assign o_sts.z_pos    = r_z > 24'sd0;
    assign o_sts.z_small  = r_z <= 24'sd4096;
    assign o_sts.onscreen = !r_colp[22] && (int'(r_colp) < SCREEN_WIDTH) &&
                            !r_rowp[22] && (int'(r_rowp) < SCREEN_HEIGHT);

endmodule

`default_nettype wire

[rtl/tpds_ctrl.sv]
// Controller: sequences the clearing sweep, read words and the plot program,
// and owns the stream handshakes. Depends on tpds_pkg.
`default_nettype none

module tpds_ctrl
    import tpds_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_s_valid,
    input  wire    i_s_opcode,
    output logic   o_s_ready,
    output logic   o_m_valid,
    input  wire    i_m_ready,
    output t_cmd   o_cmd,
    input  t_sts   i_sts
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_RDW   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_MWAIT = 4'd5;
    localparam logic [3:0] S_TEST  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_KZ    = 4'd8;
    localparam logic [3:0] S_KZW   = 4'd9;
    localparam logic [3:0] S_PX    = 4'd10;
    localparam logic [3:0] S_PY    = 4'd11;
    localparam logic [3:0] S_PW    = 4'd12;
    localparam logic [3:0] S_POS   = 4'd13;
    localparam logic [3:0] S_CMP   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0] r_state, n_state;
    t_op        r_op, n_op;
    logic [3:0] r_cnt, n_cnt;
    logic       r_m_valid, n_m_valid;
    logic       out_free;

    assign out_free  = !r_m_valid || i_m_ready;
    assign o_s_ready = r_state == S_IDLE;
    assign o_m_valid = r_m_valid;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_m_valid = r_m_valid && !i_m_ready;
        o_cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.res_clr = 1'b1;
                    n_op          = OP_CX;
                    n_state       = i_s_opcode ? S_RD : S_MUL;
                end
            end
            S_RD: begin
                o_cmd.rd_pix = 1'b1;
                n_state      = S_RDW;
            end
            S_RDW: begin
                o_cmd.wr_pix_clear = 1'b1;
                n_state            = S_DONE;
            end
            S_MUL: begin
                o_cmd.op_vld = 1'b1;
                o_cmd.op     = r_op;
                if (r_op == OP_Y) n_state = S_MWAIT;
                else              n_op    = r_op + 5'd1;
            end
            S_MWAIT: n_state = S_TEST;
            S_TEST: begin
                if (i_sts.lum_pos && i_sts.z_pos) begin
                    if (i_sts.z_small) begin
                        o_cmd.sat = 1'b1;
                        n_state   = S_KZ;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_cnt          = '0;
                        n_state        = S_DIV;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 4'd1;
                if (r_cnt == 4'd15) n_state = S_KZ;
            end
            S_KZ: begin
                o_cmd.op_vld = 1'b1;
                o_cmd.op     = OP_KZ;
                n_state      = S_KZW;
            end
            S_KZW: n_state = S_PX;
            S_PX: begin
                o_cmd.op_vld = 1'b1;
                o_cmd.op     = OP_PX;
                n_state      = S_PY;
            end
            S_PY: begin
                o_cmd.op_vld = 1'b1;
                o_cmd.op     = OP_PY;
                n_state      = S_PW;
            end
            S_PW: n_state = S_POS;
            S_POS: begin
                if (i_sts.onscreen) begin
                    o_cmd.rd_plot = 1'b1;
                    n_state       = S_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                o_cmd.wr_plot = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_op      <= OP_CX;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/torus_point_depth_shader.sv]
// Input is accepted only in idle, so one word is in flight at a time; a plot word
// issues up to 29 chained products on one shared multiplier and runs the 16-step
// reciprocal divider unless the reciprocal saturates; a point that faces away or
// lies behind ends before the projection.
// Reset: synchronous, active low; afterwards a clearing sweep blanks every entry
// of the SCREEN_WIDTH*SCREEN_HEIGHT pixel stores, input held off.
`default_nettype none

module torus_point_depth_shader
    import tpds_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] cos_tube_angle, [31:16] sin_tube_angle, [47:32] cos_ring_angle,
    // [63:48] sin_ring_angle, [68:64] pixel_row, [73:69] pixel_col, rest zero
    input  wire [79:0]        s_axis_tdata,
    // [0] opcode: 0 plot point, 1 read and clear pixel
    input  wire               s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    // [3:0] level, [4] drawn, rest zero
    output logic [7:0]        m_axis_tdata,
    input  wire               i_cfg_we,
    input  wire [CFG_IW-1:0]  i_cfg_idx,
    input  wire [CFG_DW-1:0]  i_cfg_data
);

    t_cmd       cmd;
    t_sts       sts;
    logic [3:0] level;
    logic       drawn;

    // Sequence the clearing sweep, read words and the plot program.
    tpds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .i_s_opcode (s_axis_tuser),
        .o_s_ready  (s_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Rotate, project, shade and depth test; hold the pixel stores.
    tpds_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ct       ($signed(s_axis_tdata[15:0])),
        .i_st       ($signed(s_axis_tdata[31:16])),
        .i_cp       ($signed(s_axis_tdata[47:32])),
        .i_sp       ($signed(s_axis_tdata[63:48])),
        .i_row      (s_axis_tdata[68:64]),
        .i_col      (s_axis_tdata[73:69]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_level    (level),
        .o_drawn    (drawn)
    );

    // Pack the result word.
    assign m_axis_tdata = {3'b000, drawn, level};

endmodule

`default_nettype wire

[rtl/tpds_checker.sv]
// Port-level checks for the torus point depth shader, bound to the top level.
// Depends on torus_point_depth_shader.
`default_nettype none

module tpds_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       s_axis_tvalid,
    input wire       s_axis_tready,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire [7:0] m_axis_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped or changed while stalled");

    // one word at a time: input closes right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word accepted while one is in flight");

    // no result can appear in the cycle right after an accept
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result word appeared too early");

    // clearing sweep holds off input right after reset
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !s_axis_tready)
        else $error("input accepted before stores were cleared");

endmodule

bind torus_point_depth_shader tpds_checker u_chk (.*);

`default_nettype wire
